### rtl/core/stbl_pkg.sv
// ----------------------------------------------------------------------------
// stbl_pkg: shared types and constants for the session table
// Operation and status codes, entry record layout, scan FSM states.
// ----------------------------------------------------------------------------
`default_nettype none
package stbl_pkg;

  localparam int unsigned EntriesDef = 64;
  localparam int unsigned SecPerHour = 3600;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_SET    = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_EXPIRE = 3'd3,
    OP_ADD    = 3'd4,
    OP_FCHECK = 3'd5,
    OP_MARK   = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,    // read slot, compare key next cycle
    S_LASTRD,  // read last slot for move
    S_MOVE,    // write last slot into hole
    S_XRD,     // expire: read slot
    S_XCHK,    // expire: check age
    S_OUT      // hold result
  } state_e;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] handle;
    logic [31:0] last_use;
    logic [31:0] tokens;
    logic [31:0] flush_time;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [31:0] session_value;
    logic [31:0] tokens;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [31:0] token_total;
    logic [31:0] last_use_time;
    logic        needs_flush;
    logic [6:0]  removed_count;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/core/stbl_if.sv
// ----------------------------------------------------------------------------
// stbl_if: valid/ready channel carrying one payload beat
// Generic over the payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface stbl_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/stbl_ram.sv
// ----------------------------------------------------------------------------
// stbl_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module stbl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### rtl/core/stbl_ctrl.sv
// ----------------------------------------------------------------------------
// stbl_ctrl: operation sequencer for the session table
// Walks the entry RAM for key search, insert, remove-by-move and expire.
// ----------------------------------------------------------------------------
`default_nettype none
module stbl_ctrl #(
  parameter int unsigned Entries = stbl_pkg::EntriesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire stbl_pkg::req_t             req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output stbl_pkg::rsp_t                  rsp_o,
  input  wire logic [15:0]                expiry_hours_i,
  input  wire logic [31:0]                flush_threshold_i,
  output logic                            ram_we_o,
  output logic [$clog2(Entries)-1:0]      ram_addr_o,
  output stbl_pkg::entry_t                ram_wdata_o,
  input  wire stbl_pkg::entry_t           ram_rdata_i
);
  import stbl_pkg::*;

  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  rsp_t            rsp_q, rsp_d;
  logic [CW-1:0]   cnt_q, cnt_d;      // occupied count
  logic [CW-1:0]   idx_q, idx_d;      // scan index
  logic [AW-1:0]   hole_q, hole_d;    // slot being refilled
  logic [47:0]     span_q;            // expiry window in seconds
  logic [6:0]      rmv_q, rmv_d;

  logic [32:0]     sum;
  logic [48:0]     age_lim;
  logic [CW-1:0]   last;

  assign sum     = {1'b0, ram_rdata_i.tokens} + {1'b0, req_q.tokens};
  assign age_lim = {17'd0, ram_rdata_i.last_use} + {1'b0, span_q};
  assign last    = cnt_q - CW'(1);

  // Span product registered from the expiry register every cycle
  always_ff @(posedge clk_i) begin
    span_q <= 48'(expiry_hours_i) * 48'(SecPerHour);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    idx_q  <= idx_d;
    hole_q <= hole_d;
    rmv_q  <= rmv_d;
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    hole_d      = hole_q;
    rmv_d       = rmv_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = idx_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_i;
          rsp_d = '0;
          idx_d = '0;
          rmv_d = '0;
          ram_addr_o = '0;
          if (op_e'(req_i.op) == OP_NONE) begin
            state_d = S_OUT;
          end else if (op_e'(req_i.op) == OP_EXPIRE) begin
            idx_d   = cnt_q;
            state_d = S_XRD;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // rdata holds slot idx_q (read issued last cycle)
        if (idx_q < cnt_q && ram_rdata_i.key == req_q.key) begin
          state_d = S_OUT;
          ram_wdata_o = ram_rdata_i;
          rsp_d.found_value   = ram_rdata_i.handle;
          rsp_d.token_total   = ram_rdata_i.tokens;
          rsp_d.last_use_time = ram_rdata_i.last_use;
          case (op_e'(req_q.op))
            OP_SET: begin
              ram_we_o = 1'b1;
              ram_wdata_o.handle   = req_q.session_value;
              ram_wdata_o.last_use = req_q.now;
              rsp_d.found_value    = req_q.session_value;
              rsp_d.last_use_time  = req_q.now;
            end
            OP_ADD: begin
              ram_we_o = 1'b1;
              ram_wdata_o.tokens = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              rsp_d.token_total  = ram_wdata_o.tokens;
            end
            OP_FCHECK: begin
              rsp_d.needs_flush = (ram_rdata_i.tokens >= flush_threshold_i) &&
                                  (ram_rdata_i.flush_time == '0);
            end
            OP_MARK: begin
              ram_we_o = 1'b1;
              ram_wdata_o.flush_time = req_q.now;
            end
            OP_CLEAR: begin
              rsp_d.found_value   = '0;
              rsp_d.token_total   = '0;
              rsp_d.last_use_time = '0;
              hole_d = idx_q[AW-1:0];
              if (idx_q == last) begin
                cnt_d   = last;
                state_d = S_OUT;
              end else begin
                state_d = S_LASTRD;
              end
            end
            default: ;
          endcase
        end else if (idx_q + CW'(1) >= cnt_q || idx_q >= cnt_q) begin
          // search exhausted
          state_d = S_OUT;
          if (op_e'(req_q.op) == OP_SET) begin
            if (cnt_q >= CW'(Entries)) begin
              rsp_d.status = ST_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_addr_o  = cnt_q[AW-1:0];
              ram_wdata_o = '{key: req_q.key, handle: req_q.session_value,
                              last_use: req_q.now, tokens: 32'd0,
                              flush_time: 32'd0};
              cnt_d = cnt_q + CW'(1);
              rsp_d.found_value   = req_q.session_value;
              rsp_d.last_use_time = req_q.now;
            end
          end else begin
            rsp_d.status = ST_NOTFOUND;
          end
        end else begin
          idx_d      = idx_q + CW'(1);
          ram_addr_o = idx_d[AW-1:0];
        end
      end
      S_LASTRD: begin
        ram_addr_o = last[AW-1:0];
        state_d    = S_MOVE;
      end
      S_MOVE: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = hole_q;
        ram_wdata_o = ram_rdata_i;
        cnt_d       = last;
        state_d     = (op_e'(req_q.op) == OP_EXPIRE) ? S_XRD : S_OUT;
      end
      S_XRD: begin
        // idx_q counts down; read slot idx_q-1
        if (idx_q == '0) begin
          rsp_d.removed_count = rmv_q;
          state_d = S_OUT;
        end else begin
          idx_d      = idx_q - CW'(1);
          ram_addr_o = idx_d[AW-1:0];
          state_d    = S_XCHK;
        end
      end
      S_XCHK: begin
        if (age_lim < {17'd0, req_q.now}) begin
          rmv_d  = rmv_q + 7'd1;
          hole_d = idx_q[AW-1:0];
          if (idx_q == last) begin
            cnt_d   = last;
            state_d = S_XRD;
          end else begin
            state_d = S_LASTRD;
          end
        end else begin
          state_d = S_XRD;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    rsp_o       = rsp_q;
  end
endmodule
`default_nettype wire

### rtl/core/session_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// session_table_with_aging_top: keyed session table with expiry
// ----------------------------------------------------------------------------
// One operation per beat, one result beat back. Entries sit in a single RAM
// in slot order; a search reads one slot per cycle, and a removal then moves
// the last slot into the hole unless the hole is the last slot. Expire reads
// and checks each occupied slot from the top down, with the same move for
// each removal. The single RAM port serializes these steps. The next beat
// is taken once the result has been handed off.
`default_nettype none
module session_table_with_aging_top #(
  parameter int unsigned Entries = stbl_pkg::EntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stbl_if.sink             in_if,
  stbl_if.source           out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import stbl_pkg::*;

  localparam int unsigned AW = $clog2(Entries);

  typedef enum logic [0:0] {CFG_EXPIRY = 1'b0, CFG_THRESH = 1'b1} cfg_e;

  logic [15:0]   expiry_q;
  logic [31:0]   thresh_q;
  logic          we;
  logic [AW-1:0] addr;
  entry_t        wdata, rdata;
  req_t          req;
  rsp_t          rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= 16'd24;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_EXPIRY: expiry_q <= cfg_data_i[15:0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req = in_if.data;
  assign out_if.data = rsp;

  stbl_ctrl #(.Entries(Entries)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .req_i(req),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .rsp_o(rsp),
    .expiry_hours_i(expiry_q), .flush_threshold_i(thresh_q),
    .ram_we_o(we), .ram_addr_o(addr), .ram_wdata_o(wdata), .ram_rdata_i(rdata)
  );

  stbl_ram #(.Width(EntryW), .Depth(Entries)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
endmodule
`default_nettype wire

### tb/sv/stbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbl_checker: scoreboard for the session table
// Watches request and response beats, predicts each response from its own
// copy of the table and registers, and compares the response beats in order.
// ----------------------------------------------------------------------------
module stbl_checker
  import stbl_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          occupied_o
);

  entry_t      tbl_q [Entries];
  int          occ;
  logic [15:0] age_hours;
  logic [31:0] flush_level;
  rsp_t        exp_rsp_q[$];

  assign pending_o  = exp_rsp_q.size();
  assign occupied_o = occ;

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < occ; i++) if (tbl_q[i].key == k) return i;
    return -1;
  endfunction

  // Fill the hole with the last occupied slot.
  function automatic void drop_slot(int i);
    if (i < occ - 1) tbl_q[i] = tbl_q[occ - 1];
    occ--;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t       o;
    int         s;
    int         hit;
    logic [32:0] sum;
    logic [63:0] span;
    o   = '0;
    hit = -1;
    case (op_e'(r.op))
      OP_LOOKUP, OP_CLEAR, OP_ADD, OP_FCHECK, OP_MARK: begin
        s = find_key(r.key);
        if (s < 0) begin
          o.status = ST_NOTFOUND;
        end else begin
          hit = s;
          case (op_e'(r.op))
            OP_CLEAR: begin
              drop_slot(s);
              hit = -1;
            end
            OP_ADD: begin
              sum = {1'b0, tbl_q[s].tokens} + {1'b0, r.tokens};
              tbl_q[s].tokens = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            OP_FCHECK: o.needs_flush = tbl_q[s].tokens >= flush_level &&
                                       tbl_q[s].flush_time == 0;
            OP_MARK: tbl_q[s].flush_time = r.now;
            default: ;
          endcase
        end
      end
      OP_SET: begin
        s = find_key(r.key);
        if (s >= 0) begin
          tbl_q[s].handle   = r.session_value;
          tbl_q[s].last_use = r.now;
          hit = s;
        end else if (occ >= Entries) begin
          o.status = ST_FULL;
        end else begin
          tbl_q[occ] = '{r.key, r.session_value, r.now, 32'd0, 32'd0};
          hit = occ;
          occ++;
        end
      end
      OP_EXPIRE: begin
        span = 64'(age_hours) * SecPerHour;
        for (int i = occ - 1; i >= 0; i--) begin
          if (64'(tbl_q[i].last_use) + span < 64'(r.now)) begin
            drop_slot(i);
            o.removed_count++;
          end
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      o.found_value   = tbl_q[hit].handle;
      o.token_total   = tbl_q[hit].tokens;
      o.last_use_time = tbl_q[hit].last_use;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      occ         <= 0;
      age_hours   <= 16'd24;
      flush_level <= '0;
      errors_o    <= 0;
      exp_rsp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'b0) age_hours <= cfg_data_i[15:0];
        else flush_level <= cfg_data_i;
      end
      // Compare an output beat with the oldest prediction.
      if (rsp_valid_i && rsp_ready_i) begin
        if (exp_rsp_q.size() == 0) begin
          $display("%0t: unexpected response beat %p", $time, rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          e = exp_rsp_q.pop_front();
          if (rsp_i !== e) begin
            $display("%0t: response mismatch expected %p actual %p", $time, e, rsp_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) exp_rsp_q.push_back(predict_rsp(req_i));
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: session table testbench top
// Drives directed and random table operations under varying idle and stall
// patterns, sweeps both registers, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb;
  import stbl_pkg::*;

  localparam int unsigned NumEnt   = EntriesDef;
  localparam int          MaxCycle = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          errors;
  int          pending;
  int          occupied;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_recv;
  logic [63:0] key_pool[16];

  stbl_if #(.T(req_t)) req_ch ();
  stbl_if #(.T(rsp_t)) rsp_ch ();

  session_table_with_aging_top #(.Entries(NumEnt)) uut (
    .clk_i, .rst_ni, .in_if(req_ch.sink), .out_if(rsp_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  stbl_checker #(.Entries(NumEnt)) u_chk (
    .clk_i, .rst_ni,
    .req_valid_i(req_ch.valid), .req_ready_i(req_ch.ready), .req_i(req_ch.data),
    .rsp_valid_i(rsp_ch.valid), .rsp_ready_i(rsp_ch.ready), .rsp_i(rsp_ch.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .occupied_o(occupied)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > MaxCycle) begin
        $display("[session_table_with_aging_top] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= !hold_recv && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // One request beat; valid drops at the accepting edge and stays low until the
  // task returns, and the table cannot take the next beat before then anyway.
  task automatic send_beat(op_e op, logic [63:0] key, logic [31:0] val,
                           logic [31:0] tok, logic [31:0] now);
    while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{op, key, val, tok, now};
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (NumEnt * 4 + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(5, 0))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(100, 0);
      default: return $urandom;
    endcase
  endfunction

  // Mostly keys from a small pool so ops hit; some fresh random keys.
  function automatic logic [63:0] pick_key();
    if ($urandom_range(9, 0) < 8) return key_pool[$urandom_range(15, 0)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_beats(int n);
    op_e         op;
    logic [31:0] now;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if      (r < 30) op = OP_SET;
      else if (r < 42) op = OP_LOOKUP;
      else if (r < 52) op = OP_CLEAR;
      else if (r < 58) op = OP_EXPIRE;
      else if (r < 75) op = OP_ADD;
      else if (r < 86) op = OP_FCHECK;
      else if (r < 97) op = OP_MARK;
      else op = OP_NONE;
      now = ($urandom_range(3, 0) == 0) ? rnd32() : $urandom_range(400_000, 0);
      send_beat(op, pick_key(), rnd32(), rnd32(), now);
    end
  endtask

  initial begin
    logic [63:0] k;
    rst_ni         = 1'b0;
    hold_recv      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every op, absent keys, saturation, flush mark at time zero.
    send_beat(OP_LOOKUP, 64'h0, 0, 0, 0);
    send_beat(OP_SET, 64'h0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_beat(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_beat(OP_ADD, 64'h0, 0, 32'hFFFF_FFF0, 0);
    send_beat(OP_ADD, 64'h0, 0, 32'hFFFF_FFFF, 0);
    send_beat(OP_FCHECK, 64'h0, 0, 0, 0);
    send_beat(OP_MARK, 64'h0, 0, 0, 0);
    send_beat(OP_FCHECK, 64'h0, 0, 0, 0);
    send_beat(OP_MARK, 64'h0, 0, 0, 32'd5);
    send_beat(OP_FCHECK, 64'h0, 0, 0, 0);
    send_beat(OP_ADD, 64'h1234, 0, 1, 0);
    send_beat(OP_FCHECK, 64'h1234, 0, 0, 0);
    send_beat(OP_MARK, 64'h1234, 0, 0, 7);
    send_beat(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_beat(OP_EXPIRE, 0, 0, 0, 0);
    send_beat(OP_EXPIRE, 0, 0, 0, 32'hFFFF_FFFF);
    send_beat(OP_CLEAR, 64'h0, 0, 0, 0);
    send_beat(OP_CLEAR, 64'h0, 0, 0, 0);
    // Fill to capacity, then one insert too many.
    for (int i = 0; i <= NumEnt; i++) send_beat(OP_SET, 64'(i) + 64'h100, i, 0, i * 1000);
    send_beat(OP_CLEAR, 64'h100 + NumEnt / 2, 0, 0, 0);
    write_reg(1'b0, 32'd0);
    send_beat(OP_EXPIRE, 0, 0, 0, 32'd30_500);

    // Random phases over register settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(1'b0, (ph == 2) ? 32'hFFFF : (ph == 5 ? 32'd0 : $urandom_range(100, 0)));
      write_reg(1'b1, (ph == 3) ? 32'hFFFF_FFFF : (ph == 6 ? 32'd0 : rnd32()));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off so the input side backs up.
        fork
          begin
            hold_recv = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_recv = 1'b0;
          end
          random_beats(20);
        join
      end
      random_beats(130);
      // Sender pause until all responses are back.
      while (pending != 0) @(posedge clk_i);
      // Refill the pool occasionally so fresh keys get inserted.
      k = {$urandom, $urandom};
      key_pool[2 + ph] = k;
    end

    drain();
    if (errors == 0) begin
      $display("[session_table_with_aging_top] OK");
    end else begin
      $display("[session_table_with_aging_top] ERROR");
    end
    $finish;
  end

endmodule
